### rtl/rofs_pkg.sv
// ----------------------------------------------------------------------------
// rofs_pkg
// Types, constants and level tables for the ring oscillator frequency select.
// ----------------------------------------------------------------------------
package rofs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_QUOT,
		ST_SCAN,
		ST_FINISH,
		ST_WR_LVL
	} rofs_state_t;

	typedef enum logic {
		CMD_SET_FREQ  = 1'b0,
		CMD_SET_LEVEL = 1'b1
	} rofs_cmd_t;

	// state memory layout
	localparam logic ADDR_DIV = 1'b0;
	localparam logic ADDR_LVL = 1'b1;

	localparam logic [5:0]  DIV_RESET    = 6'd16;
	localparam logic [11:0] FREQ_MIN     = 12'd25;
	localparam logic [11:0] FREQ_MAX     = 12'd2550;
	// f10 * div / 10 < 79  <=>  f10 * div < 790
	localparam logic [16:0] PROD_LIMIT   = 17'd790;
	localparam logic [11:0] RANGE_BASE   = 12'hFA4;
	localparam logic [31:0] PASSWORD     = 32'h9696_0000;
	localparam logic [31:0] DRIVE_MASK   = 32'h7777_7777;
	localparam logic [5:0]  LVL_LAST_CMP = 6'd62;
	localparam logic [5:0]  LVL_MAX      = 6'd63;

	// x / 10 == (x * RECIP10) >> RECIP_SHIFT for x < 2**18
	localparam logic [17:0] RECIP10      = 18'd209716;
	localparam int          RECIP_SHIFT  = 21;

	localparam logic [7:0] LEVEL_MHZ [64] = '{
		8'd81,
		8'd84, 8'd88, 8'd92, 8'd97, 8'd100, 8'd106, 8'd113, 8'd116,
		8'd118, 8'd121, 8'd123, 8'd126, 8'd128, 8'd131, 8'd134, 8'd136,
		8'd137, 8'd139, 8'd141, 8'd143, 8'd145, 8'd147, 8'd149, 8'd150,
		8'd101,
		8'd105, 8'd112, 8'd118, 8'd126, 8'd132, 8'd143,
		8'd145, 8'd149, 8'd153, 8'd158, 8'd161, 8'd166,
		8'd167, 8'd170, 8'd173, 8'd176, 8'd178, 8'd181,
		8'd136,
		8'd143, 8'd156, 8'd167, 8'd187,
		8'd190, 8'd198, 8'd204, 8'd213,
		8'd216, 8'd221, 8'd225, 8'd232,
		8'd217,
		8'd237, 8'd255,
		8'd255, 8'd255,
		8'd255, 8'd255
	};

	// [15:12] range bits, [11:8]/[7:4]/[3:0] boosted stage counts of drive bits 0/1/2
	localparam logic [15:0] LEVEL_CODE [64] = '{
		16'h0000,
		16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600, 16'h0700, 16'h0800,
		16'h0810, 16'h0820, 16'h0830, 16'h0840, 16'h0850, 16'h0860, 16'h0870, 16'h0880,
		16'h0881, 16'h0882, 16'h0883, 16'h0884, 16'h0885, 16'h0886, 16'h0887, 16'h0888,
		16'h1000,
		16'h1100, 16'h1200, 16'h1300, 16'h1400, 16'h1500, 16'h1600,
		16'h1610, 16'h1620, 16'h1630, 16'h1640, 16'h1650, 16'h1660,
		16'h1661, 16'h1662, 16'h1663, 16'h1664, 16'h1665, 16'h1666,
		16'h3000,
		16'h3100, 16'h3200, 16'h3300, 16'h3400,
		16'h3410, 16'h3420, 16'h3430, 16'h3440,
		16'h3441, 16'h3442, 16'h3443, 16'h3444,
		16'h2000,
		16'h2100, 16'h2300,
		16'h2310, 16'h2330,
		16'h2331, 16'h2333
	};

	// accept threshold of a level: max(midpoint to next entry, entry + 1)
	function automatic logic [8:0] level_thresh(logic [5:0] lvl);
		logic [8:0] a;
		logic [8:0] b;
		logic [8:0] mid;
		a   = {1'b0, LEVEL_MHZ[lvl]};
		b   = {1'b0, LEVEL_MHZ[lvl + 6'd1]};
		mid = (a + b) >> 1;
		return (mid > a + 9'd1) ? mid : a + 9'd1;
	endfunction

	// nibble i (0 = lsb) is boosted when it is among the top n of eight
	function automatic logic stage_on(logic [3:0] n, logic [2:0] i);
		logic [4:0] sum;
		sum = {2'b0, i} + {1'b0, n};
		return (n != 4'd0) && (n <= 4'd8) && (sum >= 5'd8);
	endfunction

	function automatic logic [31:0] drive_of(logic [5:0] lvl);
		logic [15:0] c;
		logic [31:0] k;
		c = LEVEL_CODE[lvl];
		k = '0;
		for (int i = 0; i < 8; i++) begin
			k[4*i]     = stage_on(c[11:8], 3'(i));
			k[4*i + 1] = stage_on(c[7:4], 3'(i));
			k[4*i + 2] = stage_on(c[3:0], 3'(i));
		end
		return k & DRIVE_MASK;
	endfunction

endpackage

### rtl/rofs_ram.sv
// ----------------------------------------------------------------------------
// rofs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rofs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ring_osc_freq_select_unit.sv
// ----------------------------------------------------------------------------
// ring_osc_freq_select_unit
// Picks divider, level, range code and drive words for a ring oscillator.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command per transfer:
// set by frequency (freq_tenths) or set level directly (level_request).
// Output channel (out_valid / out_stall) returns one result per command.
// One command is worked on at a time; in_stall is high from the transfer
// until the stored divider and level have been written back.
// Set level goes IDLE, LOAD, FINISH, WR_LVL. Set frequency goes IDLE, LOAD,
// DIV with d = divider doublings (0..5), QUOT, SCAN with s = table entries
// compared (1..63), then FINISH and WR_LVL. The level table is scanned one
// entry at a time over the compare unit, and the divider and level are
// written back one after the other through the single state RAM write port.
// A finished result sits in the output register while the next command is
// taken; if the receiver stalls, the next result waits in FINISH.
// Reset clears the sequencer and output valid; the stored divider reads as
// 16 until first written, no clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_osc_freq_select_unit
	import rofs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [11:0] freq_tenths,
	input  logic [5:0]  level_request,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  divider_value,
	output logic [5:0]  chosen_level,
	output logic [11:0] range_code,
	output logic [31:0] drive_word_low,
	output logic [31:0] drive_word_high,
	output logic        divider_first,
	output logic        divider_write
);

	localparam int PROD_W = 17 + 18;

	rofs_state_t state_q;
	rofs_state_t state_nxt;

	logic        cmd_q;
	logic [5:0]  req_q;
	logic [16:0] x_q;
	logic [5:0]  div_q;
	logic [5:0]  old_div_q;
	logic [12:0] f_q;
	logic [5:0]  lvl_q;
	logic        div_written_q;

	logic        out_valid_q;
	logic [5:0]  out_div_q;
	logic [5:0]  out_lvl_q;
	logic [11:0] out_range_q;
	logic [31:0] out_low_q;
	logic [31:0] out_high_q;
	logic        out_first_q;
	logic        out_wr_q;

	logic        in_xfer;
	logic        out_free;
	logic        dbl;
	logic        scan_hit;
	logic [11:0] f10_clamp;
	logic [PROD_W-1:0] quot_prod;
	logic [31:0] drive;
	logic [5:0]  stored_div;

	logic        ram_we;
	logic        ram_waddr;
	logic [5:0]  ram_wdata;
	logic        ram_re;
	logic [5:0]  ram_rdata;

	rofs_ram #(
		.WIDTH (6),
		.DEPTH (2)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADDR_DIV),
		.rdata (ram_rdata)
	);

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign dbl      = (x_q < PROD_LIMIT) && !div_q[5];
	assign scan_hit = {4'b0, level_thresh(lvl_q)} >= f_q;
	assign quot_prod = PROD_W'(x_q) * PROD_W'(RECIP10);
	assign drive    = drive_of(lvl_q);
	assign stored_div = div_written_q ? ram_rdata : DIV_RESET;

	always_comb begin
		f10_clamp = freq_tenths;
		if (freq_tenths < FREQ_MIN) begin
			f10_clamp = FREQ_MIN;
		end else if (freq_tenths > FREQ_MAX) begin
			f10_clamp = FREQ_MAX;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				state_nxt = (cmd_q == CMD_SET_LEVEL) ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				if (!dbl) state_nxt = ST_QUOT;
			end
			ST_QUOT: begin
				state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_hit || lvl_q == LVL_LAST_CMP) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_WR_LVL;
			end
			ST_WR_LVL: begin
				state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall  = 1'b1;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ADDR_DIV;
		ram_wdata = div_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ram_re   = 1'b1;
			end
			ST_FINISH: begin
				ram_we = out_free;
			end
			ST_WR_LVL: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_LVL;
				ram_wdata = lvl_q;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			div_written_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q   <= 1'b1;
				div_written_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cmd_q <= command;
					req_q <= level_request;
					x_q   <= {5'b0, f10_clamp};
				end
			end
			ST_LOAD: begin
				old_div_q <= stored_div;
				if (cmd_q == CMD_SET_LEVEL) begin
					div_q <= stored_div;
					lvl_q <= req_q;
				end else begin
					div_q <= 6'd1;
				end
			end
			ST_DIV: begin
				if (dbl) begin
					div_q <= div_q << 1;
					x_q   <= x_q << 1;
				end
			end
			ST_QUOT: begin
				f_q   <= quot_prod[RECIP_SHIFT +: 13];
				lvl_q <= '0;
			end
			ST_SCAN: begin
				if (!scan_hit) lvl_q <= lvl_q + 6'd1;
			end
			ST_FINISH: begin
				if (out_free) begin
					out_div_q   <= div_q;
					out_lvl_q   <= lvl_q;
					out_range_q <= RANGE_BASE + {8'b0, LEVEL_CODE[lvl_q][15:12]};
					out_low_q   <= PASSWORD | {16'b0, drive[15:0]};
					out_high_q  <= PASSWORD | {16'b0, drive[31:16]};
					out_first_q <= (cmd_q == CMD_SET_FREQ) && (div_q >= old_div_q);
					out_wr_q    <= (cmd_q == CMD_SET_FREQ);
				end
			end
			default: begin
				lvl_q <= lvl_q;
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign divider_value   = out_div_q;
	assign chosen_level    = out_lvl_q;
	assign range_code      = out_range_q;
	assign drive_word_low  = out_low_q;
	assign drive_word_high = out_high_q;
	assign divider_first   = out_first_q;
	assign divider_write   = out_wr_q;

endmodule
